@@ sv/can_tx_buffer_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - assertion macros
// Clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAN_TX_BUFFER_SCHEDULER_DEFINES_SVH
`define CAN_TX_BUFFER_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

`define CTBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ctbs assertion failed");

`define CTBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctbs implication failed");

`define CTBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctbs next-cycle check failed");

`else

`define CTBS_ASSERT(lbl, prop)
`define CTBS_ASSERT_IMP(lbl, ante, cons)
`define CTBS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ sv/ctbs_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - package
// Event codes, flag positions, counter levels and the queued item type.
// ----------------------------------------------------------------------------
package ctbs_pkg;

  typedef enum logic [1:0] {
    OP_SEND       = 2'd0,
    OP_TX_DONE    = 2'd1,
    OP_SYNC_CLEAR = 2'd2,
    OP_ERR_UPDATE = 2'd3
  } opcode_t;

  localparam int FLAG_TX_WARN     = 0;
  localparam int FLAG_TX_PASSIVE  = 1;
  localparam int FLAG_BUS_OFF     = 2;
  localparam int FLAG_TX_OVERFLOW = 3;
  localparam int FLAG_PDO_LATE    = 4;
  localparam int FLAG_RX_WARN     = 5;
  localparam int FLAG_RX_PASSIVE  = 6;
  localparam int FLAG_RX_OVERFLOW = 7;

  localparam logic [8:0] BUS_OFF_LEVEL = 9'd256;
  localparam logic [8:0] PASSIVE_LEVEL = 9'd128;
  localparam logic [8:0] WARN_LEVEL    = 9'd96;

  localparam int QUEUE_DEPTH = 2;
  localparam int SNAP_W      = 18;

  typedef struct packed {
    logic bus_off;
    logic tx_passive;
    logic tx_warn;
    logic rx_passive;
    logic rx_warn;
  } err_level_t;

  typedef struct packed {
    opcode_t             op;
    logic [4:0]          buf_idx;
    logic                in_range;
    logic                mbox_free;
    logic [SNAP_W-1:0]   snap;
    err_level_t          lvl;
  } ev_item_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

@@ sv/ctbs_channels.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - channel interfaces
// Valid/ready channels for events, results and the sync mask register.
// ----------------------------------------------------------------------------
interface ctbs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] buffer_index;
  logic       mailbox_free;
  logic [8:0] tx_error_count;
  logic [7:0] rx_error_count;
  logic       rx_overrun;

  modport source (output valid, opcode, buffer_index, mailbox_free, tx_error_count,
                  rx_error_count, rx_overrun, input ready);
  modport sink (input valid, opcode, buffer_index, mailbox_free, tx_error_count,
                rx_error_count, rx_overrun, output ready);
endinterface

interface ctbs_out_if;
  logic       valid;
  logic       ready;
  logic       transmit_valid;
  logic [4:0] transmit_index;
  logic       cancel_request;
  logic       send_refused;
  logic [7:0] error_flags;
  logic [5:0] pending_count;

  modport source (output valid, transmit_valid, transmit_index, cancel_request,
                  send_refused, error_flags, pending_count, input ready);
  modport sink (input valid, transmit_valid, transmit_index, cancel_request,
                send_refused, error_flags, pending_count, output ready);
endinterface

interface ctbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] sync_buffer_mask;

  modport source (output valid, sync_buffer_mask, input ready);
  modport sink (input valid, sync_buffer_mask, output ready);
endinterface

@@ sv/ctbs_front.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - front end
// Accepts events, range checks the buffer and classifies error counters.
// ----------------------------------------------------------------------------
module ctbs_front
  import ctbs_pkg::*;
#(
  parameter int BUFFER_COUNT = 32
) (
  ctbs_in_if.sink  in_ch,
  input  logic     q_ready,
  output logic     q_push,
  output ev_item_t q_item
);

  logic [8:0] txc;
  logic [7:0] rxc;

  assign txc = in_ch.tx_error_count;
  assign rxc = in_ch.rx_error_count;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  always_comb begin
    q_item.op             = opcode_t'(in_ch.opcode);
    q_item.buf_idx        = in_ch.buffer_index;
    q_item.in_range       = ({1'b0, in_ch.buffer_index} < 6'(BUFFER_COUNT));
    q_item.mbox_free      = in_ch.mailbox_free;
    q_item.snap           = {txc, rxc, in_ch.rx_overrun};
    q_item.lvl.bus_off    = (txc >= BUS_OFF_LEVEL);
    q_item.lvl.tx_passive = (txc >= PASSIVE_LEVEL);
    q_item.lvl.tx_warn    = (txc >= WARN_LEVEL);
    q_item.lvl.rx_passive = ({1'b0, rxc} >= PASSIVE_LEVEL);
    q_item.lvl.rx_warn    = ({1'b0, rxc} >= WARN_LEVEL);
  end

endmodule

@@ sv/ctbs_queue.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - event queue
// Short FIFO of classified events between front and back ends.
// ----------------------------------------------------------------------------
`include "can_tx_buffer_scheduler_defines.svh"

module ctbs_queue
  import ctbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ev_item_t push_item,
  output logic     push_ready,
  input  logic     pop,
  output logic     pop_valid,
  output ev_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ev_item_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `CTBS_ASSERT(a_q_no_overfill, !(push && !push_ready))
  `CTBS_ASSERT(a_q_no_underflow, !(pop && !pop_valid))
  `CTBS_ASSERT_IMP(a_q_ptr_gap, cnt_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

@@ sv/ctbs_back.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - back end
// Executes events against the pending mask and flags, drives the result item.
// ----------------------------------------------------------------------------
`include "can_tx_buffer_scheduler_defines.svh"

module ctbs_back
  import ctbs_pkg::*;
#(
  parameter int BUFFER_COUNT = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [BUFFER_COUNT-1:0] sync_mask,
  input  logic                    q_valid,
  input  ev_item_t                q_item,
  output logic                    q_pop,
  ctbs_out_if.source              out_ch
);

  localparam int CNT_W = $clog2(BUFFER_COUNT + 1);
  localparam int PAD_W = ((BUFFER_COUNT + 7) / 8) * 8;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_COUNT = 2'b10
  } bk_state_t;

  bk_state_t               state_r, state_nxt;
  logic [BUFFER_COUNT-1:0] pend_r, pend_nxt;
  logic                    boot_r, boot_nxt;
  logic                    sif_r, sif_nxt;
  logic [7:0]              flags_r, flags_nxt;
  logic [SNAP_W-1:0]       last_r, last_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        acc_r, acc_nxt;
  logic [PAD_W-1:0]        sh_r, sh_nxt;
  logic                    cancel_r, cancel_nxt;

  logic                    ov_r, ov_nxt;
  logic                    tv_r, tv_nxt;
  logic [4:0]              ti_r, ti_nxt;
  logic                    cx_r, cx_nxt;
  logic                    rf_r, rf_nxt;
  logic [7:0]              ef_r, ef_nxt;
  logic [5:0]              pc_r, pc_nxt;

  logic                    slot_free;
  logic                    last_chunk;
  logic [BUFFER_COUNT-1:0] req_oh;
  logic [BUFFER_COUNT-1:0] low_oh;
  logic [4:0]              low_idx;

  assign slot_free  = !ov_r || out_ch.ready;
  assign last_chunk = ((sh_r >> 8) == '0);
  assign low_oh     = pend_r & (~pend_r + 1'b1);

  always_comb begin
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      req_oh[i] = (q_item.buf_idx == 5'(i));
    end
    low_idx = '0;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        low_idx = 5'(i);
      end
    end
  end

  always_comb begin
    logic       hit;
    logic       late;
    logic       emit;
    logic [7:0] s;
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    boot_nxt   = boot_r;
    sif_nxt    = sif_r;
    flags_nxt  = flags_r;
    last_nxt   = last_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    cancel_nxt = cancel_r;
    tv_nxt     = 1'b0;
    ti_nxt     = '0;
    cx_nxt     = 1'b0;
    rf_nxt     = 1'b0;
    q_pop      = 1'b0;
    emit       = 1'b0;
    hit        = 1'b0;
    late       = 1'b0;
    s          = flags_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_SEND: begin
              emit = 1'b1;
              if (q_item.in_range) begin
                hit    = |(pend_r & req_oh);
                rf_nxt = hit;
                if (hit && !boot_r) begin
                  flags_nxt[FLAG_TX_OVERFLOW] = 1'b1;
                end
                if (pend_r == '0 && q_item.mbox_free) begin
                  tv_nxt  = 1'b1;
                  ti_nxt  = q_item.buf_idx;
                  sif_nxt = |(sync_mask & req_oh);
                end else begin
                  pend_nxt = pend_r | req_oh;
                  if (!hit) begin
                    cnt_nxt = cnt_r + 1'b1;
                  end
                end
              end
            end
            OP_TX_DONE: begin
              emit     = 1'b1;
              boot_nxt = 1'b0;
              sif_nxt  = 1'b0;
              if (pend_r != '0) begin
                pend_nxt = pend_r & ~low_oh;
                cnt_nxt  = cnt_r - 1'b1;
                tv_nxt   = 1'b1;
                ti_nxt   = low_idx;
                sif_nxt  = |(sync_mask & low_oh);
              end
            end
            OP_SYNC_CLEAR: begin
              cancel_nxt = sif_r;
              late       = sif_r;
              sif_nxt    = 1'b0;
              if ((pend_r & sync_mask) != '0) begin
                pend_nxt = pend_r & ~sync_mask;
                late     = 1'b1;
              end
              if (late) begin
                flags_nxt[FLAG_PDO_LATE] = 1'b1;
              end
              sh_nxt    = PAD_W'(pend_nxt);
              acc_nxt   = '0;
              state_nxt = BK_COUNT;
            end
            OP_ERR_UPDATE: begin
              emit = 1'b1;
              if (q_item.snap != last_r) begin
                last_nxt = q_item.snap;
                if (q_item.lvl.bus_off) begin
                  s[FLAG_BUS_OFF] = 1'b1;
                end else begin
                  s[FLAG_BUS_OFF]    = 1'b0;
                  s[FLAG_RX_WARN]    = q_item.lvl.rx_warn;
                  s[FLAG_RX_PASSIVE] = q_item.lvl.rx_passive;
                  s[FLAG_TX_WARN]    = q_item.lvl.tx_warn;
                  s[FLAG_TX_PASSIVE] = q_item.lvl.tx_passive;
                  if (!q_item.lvl.tx_passive) begin
                    s[FLAG_TX_OVERFLOW] = 1'b0;
                  end
                end
                if (q_item.snap[0]) begin
                  s[FLAG_RX_OVERFLOW] = 1'b1;
                end
                flags_nxt = s;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      BK_COUNT: begin
        if (!last_chunk || slot_free) begin
          acc_nxt = acc_r + CNT_W'(popcount8(sh_r[7:0]));
          sh_nxt  = sh_r >> 8;
          if (last_chunk) begin
            emit      = 1'b1;
            cx_nxt    = cancel_r;
            cnt_nxt   = acc_nxt;
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    ef_nxt = flags_nxt;
    pc_nxt = 6'(cnt_nxt);
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
    if (!emit) begin
      tv_nxt = tv_r;
      ti_nxt = ti_r;
      cx_nxt = cx_r;
      rf_nxt = rf_r;
      ef_nxt = ef_r;
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pend_r  <= '0;
      boot_r  <= 1'b1;
      sif_r   <= 1'b0;
      flags_r <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      boot_r  <= boot_nxt;
      sif_r   <= sif_nxt;
      flags_r <= flags_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    cancel_r <= cancel_nxt;
    tv_r     <= tv_nxt;
    ti_r     <= ti_nxt;
    cx_r     <= cx_nxt;
    rf_r     <= rf_nxt;
    ef_r     <= ef_nxt;
    pc_r     <= pc_nxt;
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.transmit_valid = tv_r;
  assign out_ch.transmit_index = ti_r;
  assign out_ch.cancel_request = cx_r;
  assign out_ch.send_refused   = rf_r;
  assign out_ch.error_flags    = ef_r;
  assign out_ch.pending_count  = pc_r;

  `CTBS_ASSERT_IMP(a_cnt_tracks_mask, state_r == BK_IDLE,
                   CNT_W'($countones(pend_r)) == cnt_r)
  `CTBS_ASSERT(a_no_pop_while_counting, !(state_r == BK_COUNT && q_pop))
  `CTBS_ASSERT_NXT(a_boot_ends, q_pop && q_item.op == OP_TX_DONE, !boot_r)
  `CTBS_ASSERT_NXT(a_late_sticky, flags_r[FLAG_PDO_LATE], flags_r[FLAG_PDO_LATE])

endmodule

@@ sv/can_tx_buffer_scheduler.sv @@
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - top level
// Pending mask scheduler for CAN transmit buffers with error state tracking.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        opcode, buffer, mailbox, error counters
//   out_ch   out  valid/ready        transmit, cancel, refused, flags, count
//   cfg_ch   in   valid/ready (=1)   sync_buffer_mask
//
// Send, transmit-done and error-update items are executed in the idle state.
// Sync-clear enters a count state: the pending count is rebuilt from the mask eight
// bits per cycle, up to the highest nonzero byte; the last byte waits for a free output slot.
// A two-item queue lets the front accept while the back end or output stalls.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module can_tx_buffer_scheduler
  import ctbs_pkg::*;
#(
  parameter int BUFFER_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ctbs_in_if.sink    in_ch,
  ctbs_out_if.source out_ch,
  ctbs_cfg_if.sink   cfg_ch
);

  logic [BUFFER_COUNT-1:0] sync_r;
  logic                    q_push;
  logic                    q_ready;
  logic                    q_pop;
  logic                    q_valid;
  ev_item_t                push_item;
  ev_item_t                pop_item;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0;
    end else if (cfg_ch.valid) begin
      sync_r <= cfg_ch.sync_buffer_mask[BUFFER_COUNT-1:0];
    end
  end

  ctbs_front #(
    .BUFFER_COUNT(BUFFER_COUNT)
  ) u_front (
    .in_ch  (in_ch),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_item (push_item)
  );

  ctbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  ctbs_back #(
    .BUFFER_COUNT(BUFFER_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .sync_mask(sync_r),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

@@ dv/ctbs_sched_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - scoreboard
// Watches the event, result and sync mask channels, keeps its own copy of the
// pending mask, bootup, sync and error state, predicts one result per
// accepted event and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module ctbs_sched_checker
  import ctbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ctbs_in_if   in_mon,
  ctbs_out_if  out_mon,
  ctbs_cfg_if  cfg_mon,
  output int   mismatch_count,
  output int   awaiting_count,
  output int   result_count,
  output int   transmit_count,
  output int   cancel_count,
  output int   refused_count
);

  typedef struct packed {
    logic       tx_valid;
    logic [4:0] tx_index;
    logic       cancel;
    logic       refused;
    logic [7:0] flags;
    logic [5:0] count;
  } sched_result_t;

  sched_result_t      expected_q[$];
  sched_result_t      exp_res;
  logic [31:0]        sync_mask;
  logic [31:0]        pending_mask;
  logic               boot_phase;
  logic               sync_busy;
  logic [7:0]         status;
  logic [SNAP_W-1:0]  last_snap;

  function automatic sched_result_t schedule_event(opcode_t op, logic [4:0] idx, logic mbox,
                                                   logic [8:0] txc, logic [7:0] rxc,
                                                   logic ovr);
    sched_result_t     r;
    logic [31:0]       sel;
    logic [SNAP_W-1:0] snap;
    logic [7:0]        s;
    logic              late;
    int                low;
    r = '0;
    sel = 32'd1 << idx;
    case (op)
      OP_SEND: begin
        if ((pending_mask & sel) != 32'd0) begin
          r.refused = 1'b1;
          if (!boot_phase) status[FLAG_TX_OVERFLOW] = 1'b1;
        end
        if (pending_mask == 32'd0 && mbox) begin
          r.tx_valid = 1'b1;
          r.tx_index = idx;
          sync_busy = (sync_mask & sel) != 32'd0;
        end else begin
          pending_mask = pending_mask | sel;
        end
      end
      OP_TX_DONE: begin
        boot_phase = 1'b0;
        sync_busy = 1'b0;
        if (pending_mask != 32'd0) begin
          low = 0;
          while (!pending_mask[low]) low++;
          pending_mask[low] = 1'b0;
          r.tx_valid = 1'b1;
          r.tx_index = low[4:0];
          sync_busy = sync_mask[low];
        end
      end
      OP_SYNC_CLEAR: begin
        late = 1'b0;
        if (sync_busy) begin
          r.cancel = 1'b1;
          sync_busy = 1'b0;
          late = 1'b1;
        end
        if ((pending_mask & sync_mask) != 32'd0) begin
          pending_mask = pending_mask & ~sync_mask;
          late = 1'b1;
        end
        if (late) status[FLAG_PDO_LATE] = 1'b1;
      end
      default: begin
        snap = {txc, rxc, ovr};
        if (snap != last_snap) begin
          s = status;
          last_snap = snap;
          if (txc >= BUS_OFF_LEVEL) begin
            s[FLAG_BUS_OFF] = 1'b1;
          end else begin
            s[FLAG_BUS_OFF] = 1'b0;
            s[FLAG_RX_WARN] = 1'b0;
            s[FLAG_RX_PASSIVE] = 1'b0;
            s[FLAG_TX_WARN] = 1'b0;
            s[FLAG_TX_PASSIVE] = 1'b0;
            if ({1'b0, rxc} >= PASSIVE_LEVEL) begin
              s[FLAG_RX_WARN] = 1'b1;
              s[FLAG_RX_PASSIVE] = 1'b1;
            end else if ({1'b0, rxc} >= WARN_LEVEL) begin
              s[FLAG_RX_WARN] = 1'b1;
            end
            if (txc >= PASSIVE_LEVEL) begin
              s[FLAG_TX_WARN] = 1'b1;
              s[FLAG_TX_PASSIVE] = 1'b1;
            end else if (txc >= WARN_LEVEL) begin
              s[FLAG_TX_WARN] = 1'b1;
            end
            if (!s[FLAG_TX_PASSIVE]) s[FLAG_TX_OVERFLOW] = 1'b0;
          end
          if (ovr) s[FLAG_RX_OVERFLOW] = 1'b1;
          status = s;
        end
      end
    endcase
    r.flags = status;
    r.count = 6'($countones(pending_mask));
    return r;
  endfunction

  task automatic report_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      sync_mask = 32'd0;
      pending_mask = 32'd0;
      boot_phase = 1'b1;
      sync_busy = 1'b0;
      status = 8'd0;
      last_snap = '0;
      mismatch_count = 0;
      awaiting_count = 0;
      result_count = 0;
      transmit_count = 0;
      cancel_count = 0;
      refused_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) sync_mask = cfg_mon.sync_buffer_mask;
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(schedule_event(opcode_t'(in_mon.opcode), in_mon.buffer_index,
                                            in_mon.mailbox_free, in_mon.tx_error_count,
                                            in_mon.rx_error_count, in_mon.rx_overrun));
      end
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item waiting, expected none, actual flags %0h",
                   $time, out_mon.error_flags);
          mismatch_count++;
        end else begin
          exp_res = expected_q.pop_front();
          report_field("transmit_valid", int'(exp_res.tx_valid),
                       int'(out_mon.transmit_valid));
          report_field("transmit_index", int'(exp_res.tx_index),
                       int'(out_mon.transmit_index));
          report_field("cancel_request", int'(exp_res.cancel),
                       int'(out_mon.cancel_request));
          report_field("send_refused", int'(exp_res.refused), int'(out_mon.send_refused));
          report_field("error_flags", int'(exp_res.flags), int'(out_mon.error_flags));
          report_field("pending_count", int'(exp_res.count), int'(out_mon.pending_count));
          if (exp_res.tx_valid) transmit_count++;
          if (exp_res.cancel) cancel_count++;
          if (exp_res.refused) refused_count++;
        end
      end
      awaiting_count = expected_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN transmit buffer scheduler - testbench top
// Drives a directed event sequence and then phases of random send,
// transmit-done, sync-clear and error-update items under several sync masks,
// with random gaps on the event channel and random result stalls.
// ----------------------------------------------------------------------------
module tb;
  import ctbs_pkg::*;

  logic        clk;
  logic        rst_n;
  bit          steady;
  int          item_count;
  logic [8:0]  last_txc;
  logic [7:0]  last_rxc;
  logic        last_ovr;
  int          mismatch_count;
  int          awaiting_count;
  int          result_count;
  int          transmit_count;
  int          cancel_count;
  int          refused_count;

  ctbs_in_if  in_if();
  ctbs_out_if out_if();
  ctbs_cfg_if cfg_if();

  can_tx_buffer_scheduler #(
    .BUFFER_COUNT(32)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  ctbs_sched_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_mon        (cfg_if),
    .mismatch_count (mismatch_count),
    .awaiting_count (awaiting_count),
    .result_count   (result_count),
    .transmit_count (transmit_count),
    .cancel_count   (cancel_count),
    .refused_count  (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int gap_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else begin
        out_if.ready = 1'b1;
        if ($urandom_range(0, 99) < 25) hold = gap_cycles();
      end
    end
  end

  task automatic drive_event(opcode_t op, logic [4:0] idx, logic mbox, logic [8:0] txc,
                             logic [7:0] rxc, logic ovr);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.opcode = op;
    in_if.buffer_index = idx;
    in_if.mailbox_free = mbox;
    in_if.tx_error_count = txc;
    in_if.rx_error_count = rxc;
    in_if.rx_overrun = ovr;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    item_count++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (awaiting_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_sync_mask(logic [31:0] mask);
    settle();
    cfg_if.sync_buffer_mask = mask;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_event();
    opcode_t    op;
    logic [4:0] idx;
    logic [8:0] txc;
    logic [7:0] rxc;
    logic       ovr;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 45) op = OP_SEND;
    else if (r < 70) op = OP_TX_DONE;
    else if (r < 80) op = OP_SYNC_CLEAR;
    else op = OP_ERR_UPDATE;
    idx = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    txc = 9'($urandom_range(0, 511));
    rxc = 8'($urandom_range(0, 255));
    ovr = ($urandom_range(0, 99) < 20);
    if (op == OP_ERR_UPDATE) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        txc = last_txc;
        rxc = last_rxc;
        ovr = last_ovr;
      end else if (r < 50) begin
        case ($urandom_range(0, 7))
          0: txc = 9'd0;
          1: txc = 9'd95;
          2: txc = 9'd96;
          3: txc = 9'd127;
          4: txc = 9'd128;
          5: txc = 9'd255;
          6: txc = 9'd256;
          default: txc = 9'd511;
        endcase
        case ($urandom_range(0, 5))
          0: rxc = 8'd0;
          1: rxc = 8'd95;
          2: rxc = 8'd96;
          3: rxc = 8'd127;
          4: rxc = 8'd128;
          default: rxc = 8'd255;
        endcase
      end
      last_txc = txc;
      last_rxc = rxc;
      last_ovr = ovr;
    end
    drive_event(op, idx, 1'($urandom_range(0, 1)), txc, rxc, ovr);
  endtask

  initial begin
    logic [31:0] masks [5];
    rst_n = 1'b0;
    steady = 1'b1;
    item_count = 0;
    last_txc = 9'd0;
    last_rxc = 8'd0;
    last_ovr = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_SEND;
    in_if.buffer_index = 5'd0;
    in_if.mailbox_free = 1'b0;
    in_if.tx_error_count = 9'd0;
    in_if.rx_error_count = 8'd0;
    in_if.rx_overrun = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.sync_buffer_mask = 32'd0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    write_sync_mask(32'h0000_000A);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd5, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd3, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd3, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd31, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SYNC_CLEAR, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_TX_DONE, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd31, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_TX_DONE, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_TX_DONE, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd1, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SYNC_CLEAR, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd96, 8'd96, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd128, 8'd128, 1'b1);
    drive_event(OP_SEND, 5'd7, 1'b0, 9'd0, 8'd0, 1'b0);
    drive_event(OP_SEND, 5'd7, 1'b1, 9'd0, 8'd0, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd511, 8'd255, 1'b1);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd256, 8'd0, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd95, 8'd95, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd95, 8'd95, 1'b0);
    drive_event(OP_ERR_UPDATE, 5'd0, 1'b0, 9'd127, 8'd127, 1'b0);
    drive_event(OP_TX_DONE, 5'd0, 1'b0, 9'd0, 8'd0, 1'b0);
    last_txc = 9'd127;
    last_rxc = 8'd127;

    masks[0] = 32'h0000_0000;
    masks[1] = 32'hFFFF_FFFF;
    masks[2] = $urandom();
    masks[3] = 32'h8000_0001;
    masks[4] = $urandom();
    for (int p = 0; p < 5; p++) begin
      write_sync_mask(masks[p]);
      steady = (p == 2);
      repeat (210) random_event();
    end

    settle();
    $display("Covered %0d items: %0d results, %0d transmits, %0d cancels, %0d refused sends",
             item_count, result_count, transmit_count, cancel_count, refused_count);
    $display("Sync masks swept through all-zero, all-one and random patterns");
    if (mismatch_count == 0 && awaiting_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
